// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/brb_pkg.sv -----
// Package for the byte ring buffer: field widths, command and status codes,
// result and control structs. No dependencies.
package brb_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 10;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  found_offset;
    logic [CNT_W-1:0]  fill_count;
  } res_t;

  typedef struct packed {
    logic done;  // result produced this cycle
    logic busy;  // a pop or peek is in progress
  } ctl_t;

endpackage

// ----- rtl/brb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/brb_ctrl.sv -----
// Ring buffer sequencer: pointers, command decode and the byte-per-cycle
// scan loop around one compare unit. Uses brb_pkg; drives brb_ram ports.
module brb_ctrl #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [brb_pkg::CMD_W-1:0]   in_command,
  input  logic [brb_pkg::BYTE_W-1:0]  in_byte_in,
  output logic                        in_ready,
  input  logic                        slot_free,
  output brb_pkg::ctl_t               ctl,
  output brb_pkg::res_t               res,
  output logic                        ram_we,
  output logic [$clog2(DEPTH)-1:0]    ram_waddr,
  output logic [brb_pkg::BYTE_W-1:0]  ram_wdata,
  output logic [$clog2(DEPTH)-1:0]    ram_raddr,
  input  logic [brb_pkg::BYTE_W-1:0]  ram_rdata
);

  localparam int AW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [AW-1:0]               rp_r, rp_nxt;
  logic [AW-1:0]               wp_r, wp_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [AW-1:0]               k_r, k_nxt;
  logic [AW-1:0]               avail_r, avail_nxt;
  logic [brb_pkg::BYTE_W-1:0]  val_r, val_nxt;

  logic [AW-1:0]               rp_inc, wp_inc, idx_inc;
  logic [AW-1:0]               held_cur;
  logic                        empty;
  logic                        accept;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] held(input logic [AW-1:0] w, input logic [AW-1:0] r);
    logic [AW:0] sum;
    sum = (AW+1)'(DEPTH) + {1'b0, w} - {1'b0, r};
    held = (w >= r) ? (w - r) : sum[AW-1:0];
  endfunction

  assign rp_inc   = wrap_inc(rp_r);
  assign wp_inc   = wrap_inc(wp_r);
  assign idx_inc  = wrap_inc(idx_r);
  assign held_cur = held(wp_r, rp_r);
  assign empty    = (wp_r == rp_r);

  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign ram_waddr = wp_r;
  assign ram_wdata = in_byte_in;

  always_comb begin
    state_nxt  = state_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    avail_nxt  = avail_r;
    val_nxt    = val_r;
    ctl.done   = 1'b0;
    ctl.busy   = (state_r != S_IDLE);
    res.byte_out     = '0;
    res.status       = brb_pkg::ST_OK;
    res.found_offset = '0;
    ram_we     = 1'b0;
    ram_raddr  = rp_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            brb_pkg::CMD_PUSH: begin
              ctl.done = 1'b1;
              if (wp_inc == rp_r) begin
                res.status = brb_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                wp_nxt = wp_inc;
              end
            end
            brb_pkg::CMD_POP: begin
              if (empty) begin
                ctl.done   = 1'b1;
                res.status = brb_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_POP;
              end
            end
            brb_pkg::CMD_PEEK: begin
              if (empty) begin
                ctl.done   = 1'b1;
                res.status = brb_pkg::ST_NOTFOUND;
              end else begin
                idx_nxt   = rp_r;
                k_nxt     = '0;
                avail_nxt = held_cur;
                val_nxt   = in_byte_in;
                state_nxt = S_SCAN;
              end
            end
            brb_pkg::CMD_FLUSH: begin
              ctl.done = 1'b1;
              rp_nxt   = '0;
              wp_nxt   = '0;
            end
            default: begin
              ctl.done = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        ctl.done     = 1'b1;
        res.byte_out = ram_rdata;
        rp_nxt       = rp_inc;
        state_nxt    = S_IDLE;
      end
      S_SCAN: begin
        // rdata holds the byte at idx_r; prefetch the next one
        ram_raddr = idx_inc;
        if (ram_rdata == val_r) begin
          ctl.done         = 1'b1;
          res.found_offset = brb_pkg::CNT_W'(k_r);
          state_nxt        = S_IDLE;
        end else if ((k_r + AW'(1)) == avail_r) begin
          ctl.done   = 1'b1;
          res.status = brb_pkg::ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
          k_nxt   = k_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res.fill_count = brb_pkg::CNT_W'(held(wp_nxt, rp_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    avail_r <= avail_nxt;
    val_r   <= val_nxt;
  end

endmodule

// ----- rtl/byte_ring_buffer_with_peek.sv -----
// Channel   Handshake               Payload
// in_       in_valid / in_ready     in_command, in_byte_in
// out_      out_valid / out_ready   out_byte_out, out_status, out_found_offset,
//                                   out_fill_count
// Push, flush, full push, empty pop and empty peek are answered straight from the command;
// a pop first reads the byte store. A peek scans from the oldest byte to a match or the last
// held byte; the single RAM read port scans one byte per cycle through one compare unit.
// Reset clears both pointers; byte store contents are not cleared.
// Results sit in an output register; a new transfer is taken while it drains.
// Top level of the byte ring buffer. Uses brb_pkg, brb_ctrl, brb_ram and
// assert_macros.svh.
`include "assert_macros.svh"

module byte_ring_buffer_with_peek #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [brb_pkg::CMD_W-1:0]   in_command,
  input  logic [brb_pkg::BYTE_W-1:0]  in_byte_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [brb_pkg::BYTE_W-1:0]  out_byte_out,
  output logic [brb_pkg::ST_W-1:0]    out_status,
  output logic [brb_pkg::CNT_W-1:0]   out_found_offset,
  output logic [brb_pkg::CNT_W-1:0]   out_fill_count
);

  localparam int AW = $clog2(DEPTH);

  brb_pkg::ctl_t               ctl;
  brb_pkg::res_t               res;
  brb_pkg::res_t               res_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        slot_free;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [brb_pkg::BYTE_W-1:0]  ram_wdata, ram_rdata;

  assign slot_free = !out_valid_r || out_ready;

  brb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_byte_in (in_byte_in),
    .in_ready   (in_ready),
    .slot_free  (slot_free),
    .ctl        (ctl),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  brb_ram #(.WIDTH(brb_pkg::BYTE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = res_r.byte_out;
  assign out_status       = res_r.status;
  assign out_found_offset = res_r.found_offset;
  assign out_fill_count   = res_r.fill_count;

  // a result never overwrites one still waiting
  `ASSERT_IMPL(a_no_overrun, ctl.done, slot_free)
  // a transfer that does not finish at once leaves the block busy
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready && !ctl.done, ctl.busy && !in_ready)
  // results without a new transfer come only from a pop or peek in progress
  `ASSERT_IMPL(a_done_source, ctl.done && !(in_valid && in_ready), ctl.busy)

endmodule

// ----- tb/tb_byte_ring_buffer_with_peek.sv -----
`timescale 1ns / 100ps
// Testbench for byte_ring_buffer_with_peek: a directed command table, then random
// push/pop/peek/flush traffic; results are checked against the table or a behavioral ring model.
// Depends on brb_pkg and the RTL of the block only.
module tb_byte_ring_buffer_with_peek;

  typedef struct {
    logic [brb_pkg::CMD_W-1:0]  cmd;
    logic [brb_pkg::BYTE_W-1:0] val;
    int                         reps;
    bit                         typed;
    brb_pkg::res_t              want;
  } step_t;

  localparam int            PLAN_LEN    = 23;
  localparam int            RAND_ITEMS  = 240;
  localparam int            QUIET_LIMIT = 20000;
  localparam brb_pkg::res_t NO_RES      = '0;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic [brb_pkg::CMD_W-1:0]  in_command = brb_pkg::CMD_FLUSH;
  logic [brb_pkg::BYTE_W-1:0] in_byte_in = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic [brb_pkg::BYTE_W-1:0] out_byte_out;
  logic [brb_pkg::ST_W-1:0]   out_status;
  logic [brb_pkg::CNT_W-1:0]  out_found_offset;
  logic [brb_pkg::CNT_W-1:0]  out_fill_count;

  logic [brb_pkg::BYTE_W-1:0] mirror [brb_pkg::DEPTH_DEF];
  logic [brb_pkg::CNT_W-1:0]  rd_idx = '0;
  logic [brb_pkg::CNT_W-1:0]  wr_idx = '0;
  brb_pkg::res_t              pending_results [$];
  int                         errors = 0;
  int                         quiet  = 0;
  bit                         steady = 1'b0;

  // full-buffer rows rely on bytes below 0xFF being pushed by the bulk fill row
  step_t plan [0:PLAN_LEN-1] = '{
    '{brb_pkg::CMD_POP,   8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_EMPTY,    10'd0,    10'd0}},
    '{brb_pkg::CMD_PEEK,  8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_NOTFOUND, 10'd0,    10'd0}},
    '{brb_pkg::CMD_FLUSH, 8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd0}},
    '{brb_pkg::CMD_PUSH,  8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd1}},
    '{brb_pkg::CMD_PUSH,  8'hFF, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd2}},
    '{brb_pkg::CMD_PUSH,  8'hA5, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd3}},
    '{brb_pkg::CMD_PEEK,  8'hFF, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd1,    10'd3}},
    '{brb_pkg::CMD_PEEK,  8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd3}},
    '{brb_pkg::CMD_PEEK,  8'h5A, 1,    1'b1, '{8'h00, brb_pkg::ST_NOTFOUND, 10'd0,    10'd3}},
    '{brb_pkg::CMD_POP,   8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd2}},
    '{brb_pkg::CMD_POP,   8'h00, 1,    1'b1, '{8'hFF, brb_pkg::ST_OK,       10'd0,    10'd1}},
    '{brb_pkg::CMD_FLUSH, 8'hFF, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd0}},
    '{brb_pkg::CMD_POP,   8'hFF, 1,    1'b1, '{8'h00, brb_pkg::ST_EMPTY,    10'd0,    10'd0}},
    '{brb_pkg::CMD_PUSH,  8'h00, 1022, 1'b0, NO_RES},
    '{brb_pkg::CMD_PUSH,  8'hFF, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0, 10'd1023}},
    '{brb_pkg::CMD_PUSH,  8'h12, 1,    1'b1, '{8'h00, brb_pkg::ST_FULL,     10'd0, 10'd1023}},
    '{brb_pkg::CMD_PEEK,  8'hFF, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,    10'd1022, 10'd1023}},
    '{brb_pkg::CMD_POP,   8'h00, 1,    1'b0, NO_RES},
    '{brb_pkg::CMD_PUSH,  8'h77, 1,    1'b0, NO_RES},
    '{brb_pkg::CMD_PEEK,  8'h77, 1,    1'b0, NO_RES},
    '{brb_pkg::CMD_FLUSH, 8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_OK,       10'd0,    10'd0}},
    '{brb_pkg::CMD_PEEK,  8'h77, 1,    1'b1, '{8'h00, brb_pkg::ST_NOTFOUND, 10'd0,    10'd0}},
    '{brb_pkg::CMD_POP,   8'h00, 1,    1'b1, '{8'h00, brb_pkg::ST_EMPTY,    10'd0,    10'd0}}
  };

  byte_ring_buffer_with_peek #(.DEPTH(brb_pkg::DEPTH_DEF)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_out     (out_byte_out),
    .out_status       (out_status),
    .out_found_offset (out_found_offset),
    .out_fill_count   (out_fill_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic brb_pkg::res_t ring_step(input logic [brb_pkg::CMD_W-1:0] cmd,
                                              input logic [brb_pkg::BYTE_W-1:0] val);
    brb_pkg::res_t             r;
    logic [brb_pkg::CNT_W-1:0] held;
    logic [brb_pkg::CNT_W-1:0] nxt;
    logic [brb_pkg::CNT_W-1:0] at;
    bit                        hit;
    r    = '0;
    held = wr_idx - rd_idx;
    nxt  = wr_idx + 1'b1;
    hit  = 1'b0;
    case (cmd)
      brb_pkg::CMD_PUSH: begin
        if (nxt == rd_idx) begin
          r.status = brb_pkg::ST_FULL;
        end else begin
          mirror[wr_idx] = val;
          wr_idx = nxt;
        end
      end
      brb_pkg::CMD_POP: begin
        if (held == '0) begin
          r.status = brb_pkg::ST_EMPTY;
        end else begin
          r.byte_out = mirror[rd_idx];
          rd_idx = rd_idx + 1'b1;
        end
      end
      brb_pkg::CMD_PEEK: begin
        for (int i = 0; i < held && !hit; i++) begin
          at = rd_idx + brb_pkg::CNT_W'(i);
          if (mirror[at] == val) begin
            hit = 1'b1;
            r.found_offset = brb_pkg::CNT_W'(i);
          end
        end
        if (!hit) r.status = brb_pkg::ST_NOTFOUND;
      end
      default: begin
        rd_idx = '0;
        wr_idx = '0;
      end
    endcase
    r.fill_count = wr_idx - rd_idx;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    errors++;
  endtask

  // called at a rising edge; returns at the rising edge that completes the transfer
  task automatic send_cmd(input logic [brb_pkg::CMD_W-1:0] cmd,
                          input logic [brb_pkg::BYTE_W-1:0] val,
                          input bit typed, input brb_pkg::res_t want);
    brb_pkg::res_t predicted;
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_byte_in <= val;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    predicted = ring_step(cmd, val);
    pending_results.push_back(typed ? want : predicted);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 21);
  end

  always @(negedge clk) begin
    brb_pkg::res_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with no result pending");
        end else begin
          want = pending_results.pop_front();
          if (out_byte_out !== want.byte_out)
            report_mismatch($sformatf("byte_out got 0x%0h, expected 0x%0h",
                                      out_byte_out, want.byte_out));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_status, want.status));
          if (out_found_offset !== want.found_offset)
            report_mismatch($sformatf("found_offset got %0d, expected %0d",
                                      out_found_offset, want.found_offset));
          if (out_fill_count !== want.fill_count)
            report_mismatch($sformatf("fill_count got %0d, expected %0d",
                                      out_fill_count, want.fill_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int                         mode;
    int                         roll;
    int                         push_pct;
    int                         pop_pct;
    bit                         narrow;
    logic [brb_pkg::CNT_W-1:0]  held;
    logic [brb_pkg::CMD_W-1:0]  cmd;
    logic [brb_pkg::BYTE_W-1:0] val;
    mode   = 2;
    narrow = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int r = 0; r < plan[i].reps; r++) begin
        val = (plan[i].reps > 1) ? brb_pkg::BYTE_W'($urandom_range(0, 254)) : plan[i].val;
        send_cmd(plan[i].cmd, val, plan[i].typed, plan[i].want);
      end
    end

    // phases lean toward filling or draining, or stay balanced, so the fill level wanders widely
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) begin
        mode   = $urandom_range(0, 2);
        narrow = 1'($urandom_range(0, 1));
      end
      steady = (n >= 60 && n < 180);
      case (mode)
        0:       begin push_pct = 70; pop_pct = 12; end
        1:       begin push_pct = 15; pop_pct = 65; end
        default: begin push_pct = 40; pop_pct = 35; end
      endcase
      roll = $urandom_range(99);
      if (roll < push_pct) cmd = brb_pkg::CMD_PUSH;
      else if (roll < push_pct + pop_pct) cmd = brb_pkg::CMD_POP;
      else if (roll < 98) cmd = brb_pkg::CMD_PEEK;
      else cmd = brb_pkg::CMD_FLUSH;
      val  = narrow ? brb_pkg::BYTE_W'($urandom_range(0, 7))
                    : brb_pkg::BYTE_W'($urandom_range(0, 255));
      held = wr_idx - rd_idx;
      if (cmd == brb_pkg::CMD_PEEK && held != '0 && $urandom_range(99) < 60)
        val = mirror[rd_idx + brb_pkg::CNT_W'($urandom_range(0, int'(held) - 1))];
      send_cmd(cmd, val, 1'b0, NO_RES);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
